// ===== design/cwt_pkg.sv =====
// Shared types and constants for the configuration word tokenizer.
// Used by cwt_lex and config_word_tokenizer_top; depends on nothing else.
package cwt_pkg;

    // Kind of one result item.
    typedef enum logic [1:0] {
        KIND_BYTE       = 2'd0,
        KIND_WORD_END   = 2'd1,
        KIND_LINE_END   = 2'd2,
        KIND_STREAM_END = 2'd3
    } kind_t;

    // Scanner position within the text.
    typedef enum logic [1:0] {
        PH_COL0    = 2'd0,
        PH_GAP     = 2'd1,
        PH_WORD    = 2'd2,
        PH_COMMENT = 2'd3
    } phase_t;

    // Open quote, if any.
    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } quote_t;

    localparam int MaxResults = 3;
    localparam logic [2:0] TailLen = 3'd6;

    // Character codes.
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChHash    = 8'h23;
    localparam logic [7:0] ChDquote  = 8'h22;
    localparam logic [7:0] ChSquote  = 8'h27;
    localparam logic [7:0] ChParen   = 8'h28;

    // The word "active", newest byte lowest.
    localparam logic [47:0] ActiveTail = 48'h616374697665;

    // One result item.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       keyword;
    } tok_t;

    // All results of one input request.
    typedef struct packed {
        logic [1:0]                cnt;
        tok_t [MaxResults-1:0]     ent;
    } tok_set_t;

    function automatic tok_t mk_tok(kind_t kind, logic [7:0] data, logic keyword);
        tok_t t;
        t.kind    = kind;
        t.data    = data;
        t.keyword = keyword;
        return t;
    endfunction

endpackage

// ===== design/cwt_lex.sv =====
// Tokenizer state and per-byte decision logic.
// Depends on cwt_pkg for the result, phase and quote types.
module cwt_lex
    import cwt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    input  logic       group_lines,
    output tok_set_t   res
);

    phase_t      phase_reg, phase_next;
    quote_t      quote_reg, quote_next;
    logic        line_open_reg, line_open_next;
    logic        kw_reg, kw_next;
    logic [47:0] recent_reg, recent_next;
    logic [2:0]  count_reg, count_next;

    // State registers advance once per processed request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_COL0;
            quote_reg     <= Q_NONE;
            line_open_reg <= 1'b0;
            kw_reg        <= 1'b0;
            recent_reg    <= '0;
            count_reg     <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            quote_reg     <= quote_next;
            line_open_reg <= line_open_next;
            kw_reg        <= kw_next;
            recent_reg    <= recent_next;
            count_reg     <= count_next;
        end
    end

    // Decide next state and the results caused by this byte.
    always_comb begin
        logic        do_word;
        logic        start;
        logic        lo_eff;
        quote_t      wq;
        logic [2:0]  wcnt;
        logic [47:0] wrec;
        logic [7:0]  c;
        logic [1:0]  n;

        phase_next     = phase_reg;
        quote_next     = quote_reg;
        line_open_next = line_open_reg;
        kw_next        = kw_reg;
        recent_next    = recent_reg;
        count_next     = count_reg;
        res            = '0;
        n              = 2'd0;
        do_word        = 1'b0;
        start          = 1'b0;
        lo_eff         = line_open_reg;
        c              = in_byte;

        if (end_of_stream) begin
            // Close the open word and line, then return to reset state.
            if (phase_reg == PH_WORD) begin
                res.ent[n] = mk_tok(KIND_WORD_END, 8'h00, kw_reg);
                n = n + 2'd1;
            end
            if (line_open_reg) begin
                res.ent[n] = mk_tok(KIND_LINE_END, 8'h00, 1'b0);
                n = n + 2'd1;
            end
            res.ent[n] = mk_tok(KIND_STREAM_END, 8'h00, 1'b0);
            n = n + 2'd1;
            phase_next     = PH_COL0;
            quote_next     = Q_NONE;
            line_open_next = 1'b0;
            kw_next        = 1'b0;
            recent_next    = '0;
            count_next     = '0;
        end else begin
            case (phase_reg)
                PH_COMMENT: begin
                    if (c == ChNewline) phase_next = PH_COL0;
                end
                PH_WORD: begin
                    do_word = 1'b1;
                end
                default: begin
                    if (c == ChNewline) begin
                        phase_next = PH_COL0;
                    end else if (c == ChHash) begin
                        phase_next = PH_COMMENT;
                    end else if (c == ChSpace || c == ChTab) begin
                        phase_next = PH_GAP;
                    end else begin
                        // A word at column 0 closes the open logical line.
                        if (line_open_reg && phase_reg == PH_COL0) begin
                            res.ent[n] = mk_tok(KIND_LINE_END, 8'h00, 1'b0);
                            n = n + 2'd1;
                            lo_eff = 1'b0;
                        end
                        kw_next        = group_lines && !lo_eff;
                        line_open_next = group_lines ? 1'b1 : lo_eff;
                        phase_next     = PH_WORD;
                        start          = 1'b1;
                        do_word        = 1'b1;
                    end
                end
            endcase
        end

        // Word character handling; a fresh word starts with cleared tail.
        wq   = start ? Q_NONE : quote_reg;
        wcnt = start ? 3'd0 : count_reg;
        wrec = start ? 48'd0 : recent_reg;
        if (do_word) begin
            quote_next  = wq;
            count_next  = wcnt;
            recent_next = wrec;
            if (c == ChParen && wcnt >= TailLen && wrec == ActiveTail) begin
                c = ChSpace;
            end
            if (c == ChNewline) begin
                res.ent[n] = mk_tok(KIND_WORD_END, 8'h00, kw_next);
                n = n + 2'd1;
                quote_next = Q_NONE;
                phase_next = PH_COL0;
            end else if (wq == Q_NONE && (c == ChSpace || c == ChTab)) begin
                res.ent[n] = mk_tok(KIND_WORD_END, 8'h00, kw_next);
                n = n + 2'd1;
                phase_next = PH_GAP;
            end else if ((wq == Q_SINGLE && c == ChSquote) ||
                         (wq == Q_DOUBLE && c == ChDquote)) begin
                quote_next = Q_NONE;
            end else if (wq == Q_NONE && c == ChSquote) begin
                quote_next = Q_SINGLE;
            end else if (wq == Q_NONE && c == ChDquote) begin
                quote_next = Q_DOUBLE;
            end else begin
                res.ent[n] = mk_tok(KIND_BYTE, c, kw_next);
                n = n + 2'd1;
                recent_next = {wrec[39:0], c};
                if (wcnt < TailLen) count_next = wcnt + 3'd1;
            end
        end

        res.cnt = n;
    end

endmodule

// ===== design/config_word_tokenizer_top.sv =====
// A request passes through the input register and then the result register before its
// first result is presented; it waits in the input register while the result register
// is not free. One request per cycle is accepted while each causes at most one result
// and m_tready is high; a request's results leave one per cycle while m_tready is high.
// Reset (aresetn low, synchronous) empties both registers, returns the scanner to line
// start and sets group_lines to 1.
// Top level of the configuration word tokenizer; depends on cwt_pkg and cwt_lex.
module config_word_tokenizer_top
    import cwt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: group_lines
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // Input request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_stream
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [8] keyword, [15:9] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast     // last
);

    logic       group_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    tok_t [MaxResults-1:0] ent_reg;
    logic [1:0] cnt_reg;

    logic       advance;
    logic       q_free;
    logic       pop;
    tok_set_t   res;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            group_reg <= cfg_wr_data;
        end
    end

    // Handshake: the result register takes a new set once it is empty or
    // its final entry is leaving.
    assign pop      = m_tvalid && m_tready;
    assign q_free   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign advance  = in_valid_reg && q_free;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    // Scanner state and per-byte decision.
    cwt_lex u_lex (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .in_byte       (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .group_lines   (group_reg),
        .res           (res)
    );

    // Result register: holds one request's results and shifts them out.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (advance) begin
            cnt_reg <= res.cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ent_reg <= res.ent;
        end else if (pop) begin
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

    // Output fields.
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {7'd0, ent_reg[0].keyword, ent_reg[0].data};
    assign m_tuser  = ent_reg[0].kind;
    assign m_tlast  = (cnt_reg == 2'd1);

endmodule
